// ----- sv/polygon_perimeter_area_top_macros.svh -----
// Assertion helpers for the top level of this block.
`ifndef POLYGON_PERIMETER_AREA_TOP_MACROS_SVH
`define POLYGON_PERIMETER_AREA_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PPA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ppa_pkg.sv -----
package ppa_pkg;

    localparam int IN_COORD_W = 24;
    localparam int PERIM_W    = 40;
    localparam int AREA_W     = 62;
    localparam int TOTAL_W    = 11;

    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;
    localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_ROOT,
        BK_ACC,
        BK_OUT
    } bk_state_t;

    // Per-vertex control flags carried through the queue.
    typedef struct packed {
        logic last;
        logic close;
    } ppa_ctl_t;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic idle;
        logic out_wait;
        logic closing;
        logic last_item;
    } ppa_bk_stat_t;

endpackage

// ----- sv/ppa_front.sv -----
module ppa_front #(
    parameter int COORD_BITS   = 24,
    parameter int MAX_VERTICES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ppa_pkg::IN_COORD_W-1:0]    in_x,
    input  logic [ppa_pkg::IN_COORD_W-1:0]    in_y,
    input  logic                              in_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    output logic                              q_push,
    input  logic                              q_ready,
    output logic [$bits(ppa_pkg::ppa_ctl_t) + $clog2(MAX_VERTICES+1)
                  + 8*(COORD_BITS+1) - 1:0]   q_data
);
    import ppa_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic signed [CB-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [CW-1:0]        seen_reg, seen_next;
    logic                 closed_reg;

    logic signed [CB-1:0] cur_x, cur_y, first_x_eff, first_y_eff;
    logic signed [DW-1:0] edge_dx, edge_dy, ux, uy, vx, vy, cdx, cdy;
    logic                 has_prev, has_tri, accept;
    logic [CW-1:0]        count_inc;
    ppa_ctl_t             ctl;

    assign in_ready  = q_ready;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && q_ready;
    assign q_push    = accept;

    // Bits above the coordinate width are dropped; a wider coordinate is zero-filled.
    assign cur_x = $signed(CB'(in_x));
    assign cur_y = $signed(CB'(in_y));

    assign has_prev    = (seen_reg != '0);
    assign has_tri     = (seen_reg >= CW'(2));
    assign first_x_eff = has_prev ? first_x_reg : cur_x;
    assign first_y_eff = has_prev ? first_y_reg : cur_y;

    always_comb begin
        edge_dx = '0;
        edge_dy = '0;
        ux      = '0;
        uy      = '0;
        vx      = '0;
        vy      = '0;
        cdx     = '0;
        cdy     = '0;
        if (has_prev) begin
            edge_dx = DW'(cur_x) - DW'(prev_x_reg);
            edge_dy = DW'(cur_y) - DW'(prev_y_reg);
        end
        if (has_tri) begin
            ux = DW'(prev_x_reg) - DW'(first_x_reg);
            uy = DW'(prev_y_reg) - DW'(first_y_reg);
            vx = DW'(cur_x) - DW'(first_x_reg);
            vy = DW'(cur_y) - DW'(first_y_reg);
        end
        if (in_last && closed_reg) begin
            cdx = DW'(first_x_eff) - DW'(cur_x);
            cdy = DW'(first_y_eff) - DW'(cur_y);
        end
    end

    // The count stops at the vertex limit; geometry keeps accumulating.
    assign count_inc = (seen_reg < CW'(MAX_VERTICES)) ? seen_reg + CW'(1) : seen_reg;
    assign seen_next = in_last ? '0 : count_inc;

    assign ctl.last  = in_last;
    assign ctl.close = in_last && closed_reg;

    assign q_data = {ctl, count_inc, edge_dx, edge_dy, ux, uy, vx, vy, cdx, cdy};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= '0;
            closed_reg <= 1'b1;
        end else begin
            if (cfg_valid) begin
                closed_reg <= cfg_data;
            end
            if (accept) begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!has_prev) begin
                first_x_reg <= cur_x;
                first_y_reg <= cur_y;
            end
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
    end

endmodule

// ----- sv/ppa_fifo.sv -----
module ppa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] out_data
);
    import ppa_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ----- sv/ppa_back.sv -----
module ppa_back #(
    parameter int COORD_BITS   = 24,
    parameter int MAX_VERTICES = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  logic [$bits(ppa_pkg::ppa_ctl_t) + $clog2(MAX_VERTICES+1)
                  + 8*(COORD_BITS+1) - 1:0]      q_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ppa_pkg::PERIM_W-1:0]          out_perimeter,
    output logic [ppa_pkg::AREA_W-1:0]           out_area,
    output logic [ppa_pkg::TOTAL_W-1:0]          out_total,
    output ppa_pkg::ppa_bk_stat_t                stat
);
    import ppa_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int RW  = DW + 1;
    localparam int SCW = $clog2(RW);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int HW  = (PW > AREA_W) ? PW : AREA_W;
    localparam int VW  = (CW > TOTAL_W) ? CW : TOTAL_W;

    bk_state_t            state_reg, state_next;
    ppa_ctl_t             ctl_reg, q_ctl;
    logic [CW-1:0]        cnt_reg, q_cnt;
    logic signed [DW-1:0] dx_reg, dy_reg, ux_reg, uy_reg, vx_reg, vy_reg, cdx_reg, cdy_reg;
    logic signed [DW-1:0] q_dx, q_dy, q_ux, q_uy, q_vx, q_vy, q_cdx, q_cdy;
    logic                 closing_reg, closing_next;

    logic signed [PW-1:0] sqx_reg, sqy_reg, pa_reg, pb_reg;
    logic [2*RW-1:0]      rad_reg;
    logic [RW-1:0]        rem_reg, root_reg;
    logic [SCW-1:0]       step_reg;
    logic [AREA_W-1:0]    term_reg;
    logic [PERIM_W-1:0]   len_reg, len_next;
    logic [AREA_W-1:0]    area_reg, area_next;

    logic                 m_valid_reg, m_valid_next, load_out;
    logic [PERIM_W-1:0]   perim_out_reg;
    logic [AREA_W-1:0]    area_out_reg;
    logic [TOTAL_W-1:0]   total_out_reg, total_val;

    logic [NW-1:0]        norm_sq;
    logic signed [PW:0]   cross_dif;
    logic [PW:0]          cross_abs;
    logic [HW-1:0]        half_ext;
    logic [AREA_W-1:0]    term_val;
    logic [RW+1:0]        rem_sh, trial;
    logic                 root_ge;
    logic [PERIM_W:0]     len_sum;
    logic [AREA_W:0]      area_sum;
    logic [VW-1:0]        cnt_ext;

    assign {q_ctl, q_cnt, q_dx, q_dy, q_ux, q_uy, q_vx, q_vy, q_cdx, q_cdy} = q_data;

    // Squared edge length and half of the fan triangle's cross product.
    assign norm_sq   = NW'($unsigned(sqx_reg)) + NW'($unsigned(sqy_reg));
    assign cross_dif = (PW+1)'(pa_reg) - (PW+1)'(pb_reg);
    assign cross_abs = cross_dif[PW] ? $unsigned(-cross_dif) : $unsigned(cross_dif);
    assign half_ext  = HW'(cross_abs[PW:1]);
    assign term_val  = (half_ext > HW'(AREA_MAX)) ? AREA_MAX : half_ext[AREA_W-1:0];

    // One root bit per cycle, restoring method.
    assign rem_sh  = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    assign len_sum  = (PERIM_W+1)'(len_reg) + (PERIM_W+1)'(root_reg);
    assign area_sum = (AREA_W+1)'(area_reg) + (AREA_W+1)'(term_reg);

    assign cnt_ext   = VW'(cnt_reg);
    assign total_val = (cnt_ext > VW'(TOTAL_MAX)) ? TOTAL_MAX : cnt_ext[TOTAL_W-1:0];

    always_comb begin
        state_next   = state_reg;
        closing_next = closing_reg;
        len_next     = len_reg;
        area_next    = area_reg;
        m_valid_next = m_valid_reg && !out_ready;
        load_out     = 1'b0;
        q_pop        = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_pop = 1'b1;
                if (q_valid) begin
                    closing_next = 1'b0;
                    state_next   = BK_MUL;
                end
            end
            BK_MUL: begin
                state_next = BK_SUM;
            end
            BK_SUM: begin
                state_next = BK_ROOT;
            end
            BK_ROOT: begin
                if (step_reg == SCW'(RW - 1)) begin
                    state_next = BK_ACC;
                end
            end
            BK_ACC: begin
                len_next = len_sum[PERIM_W] ? PERIM_MAX : len_sum[PERIM_W-1:0];
                if (!closing_reg) begin
                    area_next = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
                end
                if (!closing_reg && ctl_reg.close) begin
                    closing_next = 1'b1;
                    state_next   = BK_MUL;
                end else if (ctl_reg.last) begin
                    state_next = BK_OUT;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_OUT: begin
                if (!m_valid_reg || out_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    len_next     = '0;
                    area_next    = '0;
                    state_next   = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            closing_reg <= 1'b0;
            len_reg     <= '0;
            area_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            len_reg     <= len_next;
            area_reg    <= area_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_IDLE && q_valid) begin
            ctl_reg <= q_ctl;
            cnt_reg <= q_cnt;
            dx_reg  <= q_dx;
            dy_reg  <= q_dy;
            ux_reg  <= q_ux;
            uy_reg  <= q_uy;
            vx_reg  <= q_vx;
            vy_reg  <= q_vy;
            cdx_reg <= q_cdx;
            cdy_reg <= q_cdy;
        end
        if (state_reg == BK_ACC && !closing_reg && ctl_reg.close) begin
            dx_reg <= cdx_reg;
            dy_reg <= cdy_reg;
        end
        if (state_reg == BK_MUL) begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            pa_reg  <= ux_reg * vy_reg;
            pb_reg  <= uy_reg * vx_reg;
        end
        if (state_reg == BK_SUM) begin
            rad_reg  <= (2*RW)'(norm_sq);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
            term_reg <= term_val;
        end
        if (state_reg == BK_ROOT) begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= root_ge ? RW'(rem_sh - trial) : RW'(rem_sh);
            root_reg <= {root_reg[RW-2:0], root_ge};
            step_reg <= step_reg + SCW'(1);
        end
        if (load_out) begin
            perim_out_reg <= len_reg;
            area_out_reg  <= area_reg;
            total_out_reg <= total_val;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_perimeter = perim_out_reg;
    assign out_area      = area_out_reg;
    assign out_total     = total_out_reg;

    assign stat.idle      = (state_reg == BK_IDLE);
    assign stat.out_wait  = (state_reg == BK_OUT);
    assign stat.closing   = closing_reg;
    assign stat.last_item = ctl_reg.last;

endmodule

// ----- sv/polygon_perimeter_area_top.sv -----
// Channel  | Direction | Signals                       | Contents
// ---------+-----------+-------------------------------+-------------------------------------
// s_       | in        | s_tvalid s_tready s_tdata s_tlast | one vertex; tlast marks the last one
// m_       | out       | m_tvalid m_tready m_tdata     | perimeter, area, vertex count
// cfg_     | in        | cfg_valid cfg_ready cfg_data  | closed-mode bit
//
// Each vertex passes through the back end's multiply, sum, root and accumulate states:
// the square root produces one bit per cycle, so it takes the longest. A last vertex in
// closed mode runs those states again for the closing edge, then loads the result.
// Reset is synchronous and active low; closed mode comes out of reset set.
// A two-entry queue lets the input side take vertices while the back end works, and a
// finished result waits in the output register without stopping the back end early.
module polygon_perimeter_area_top #(
    parameter int COORD_BITS   = 24,
    parameter int MAX_VERTICES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Vertex transfers. s_tdata, from bit 0: x_coord[23:0], y_coord[23:0].
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic         s_tlast,
    // Result transfers. m_tdata, from bit 0: perimeter[39:0], area[61:0],
    // vertex_total[10:0], then seven zero bits.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,
    // Closed-mode register write.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);
    import ppa_pkg::*;

    `include "polygon_perimeter_area_top_macros.svh"

    localparam int ENTRY_W = $bits(ppa_ctl_t) + $clog2(MAX_VERTICES + 1)
                             + 8 * (COORD_BITS + 1);

    logic               q_push, q_ready, q_valid, q_pop;
    logic [ENTRY_W-1:0] q_in_data, q_out_data;
    logic [PERIM_W-1:0] res_perimeter;
    logic [AREA_W-1:0]  res_area;
    logic [TOTAL_W-1:0] res_total;
    ppa_bk_stat_t       bk_stat;

    // The front end keeps the first and previous vertex and turns each transfer
    // into edge and fan-triangle differences.
    ppa_front #(
        .COORD_BITS   (COORD_BITS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[IN_COORD_W-1:0]),
        .in_y      (s_tdata[2*IN_COORD_W-1:IN_COORD_W]),
        .in_last   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_ready   (q_ready),
        .q_data    (q_in_data)
    );

    ppa_fifo #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_ready),
        .in_data   (q_in_data),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_data  (q_out_data)
    );

    // The back end squares, takes the root, forms the triangle term and accumulates.
    ppa_back #(
        .COORD_BITS   (COORD_BITS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_out_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_perimeter (res_perimeter),
        .out_area      (res_area),
        .out_total     (res_total),
        .stat          (bk_stat)
    );

    assign m_tdata = {7'd0, res_total, res_area, res_perimeter};

    // A new result appears only after the back end sat in its output state.
    `PPA_ASSERT_NOW(a_result_from_out_state, aclk, aresetn, $rose(m_tvalid),
        $past(bk_stat.out_wait), "result valid rose outside the output state")

    // An idle back end picks up a queued entry at once.
    `PPA_ASSERT_NEXT(a_idle_takes_entry, aclk, aresetn, q_valid && bk_stat.idle,
        !bk_stat.idle, "back end stayed idle with a queued entry")

    // The closing edge is only ever worked on for the last vertex of a figure.
    `PPA_ASSERT_NOW(a_closing_only_last, aclk, aresetn, bk_stat.closing && !bk_stat.idle,
        bk_stat.last_item, "closing edge started for a vertex that is not last")

endmodule

// ----- sim/polygon_perimeter_area_top_tb.sv -----
// Self-checking bench for polygon_perimeter_area_top.
//
// Vertices go in on the s_ stream and each figure ends at the vertex that
// carries tlast. A behavioral predictor runs on every accepted vertex and
// keeps its own figure state. The predictor covers the first and previous
// vertex, the vertex count, the Q8 perimeter sum and the Q16 fan-area sum. It
// pushes one expected result per figure. A separate process pops the oldest
// expectation for every result transfer on the m_ stream and compares the
// three fields.
module polygon_perimeter_area_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppa_pkg::*;

    // The block is built with its default vertex cap.
    localparam int FIG_VERTEX_CAP = 1024;

    // Closed-mode register values.
    localparam bit MODE_OPEN   = 1'b0;
    localparam bit MODE_CLOSED = 1'b1;

    // The drain wait covers a vertex in the back end, up to two vertices
    // that can sit in the input queue behind it, and a closing edge. This
    // is the quiet time allowed after the last result before the block is
    // treated as idle.
    localparam int DRAIN_CYCLES   = 5 * (IN_COORD_W + 6) + 16;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_VERTICES = 700;

    localparam logic [IN_COORD_W-1:0] COORD_MIN = 24'h800000;
    localparam logic [IN_COORD_W-1:0] COORD_MAX = 24'h7FFFFF;

    // Ways of choosing the next vertex of a random figure.
    typedef enum int {
        PICK_FULL,
        PICK_EXTREME,
        PICK_REPEAT,
        PICK_NEAR
    } coord_pick_t;

    // One expected figure summary, field for field as it leaves on m_tdata.
    typedef struct {
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
        logic [TOTAL_W-1:0] vertex_total;
    } figure_result_t;

    // Clock and reset. Every input of the block has a known value from time 0.
    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [119:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data  = 1'b0;

    always #10 aclk = ~aclk;

    polygon_perimeter_area_top #(
        .COORD_BITS  (IN_COORD_W),
        .MAX_VERTICES(FIG_VERTEX_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Predictor state. It mirrors the block's accumulators and the register.
    bit                 closed_mode_q = MODE_CLOSED;
    longint             fig_first_x, fig_first_y, fig_prev_x, fig_prev_y;
    int unsigned        fig_count;
    logic [PERIM_W-1:0] fig_perim = '0;
    logic [AREA_W-1:0]  fig_area  = '0;

    figure_result_t expected_figures[$];

    // Bookkeeping for the checker and the summary.
    int  mismatch_count;
    int  figures_checked;
    int  vertices_sent;
    int  cycle_count;
    bit  saw_mode_open, saw_mode_closed;

    // Idling controls. The steady flags give stretches with no idling on a
    // side. A hold request makes the receiver refuse results for a long run.
    bit  tx_steady;
    bit  rx_steady;
    bit  rx_hold_req;
    int  rx_hold_left;
    int  rx_stall_left;

    // Mostly short gaps, now and then a long one.
    function automatic int rand_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Edge length in Q8: the square root, rounded down, of the exact squared
    // distance in Q16.
    function automatic logic [PERIM_W-1:0] edge_length(input longint ax, input longint ay,
                                                       input longint bx, input longint by);
        logic [63:0]  dx, dy, root;
        logic [127:0] sum_sq, trial;
        dx = (bx >= ax) ? bx - ax : ax - bx;
        dy = (by >= ay) ? by - ay : ay - by;
        sum_sq = dx * dx + dy * dy;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sum_sq) begin
                root = trial[63:0];
            end
        end
        return root[PERIM_W-1:0];
    endfunction

    // Fan triangle (first, previous, current): half the absolute cross
    // product, rounded down, saturated to the area width.
    function automatic logic [AREA_W-1:0] fan_triangle(input longint px, input longint py,
                                                       input longint cx, input longint cy);
        longint      twice;
        logic [63:0] half;
        twice = (px - fig_first_x) * (cy - fig_first_y)
              - (py - fig_first_y) * (cx - fig_first_x);
        if (twice < 0) begin
            twice = -twice;
        end
        half = twice;
        half = half >> 1;
        return (half > AREA_MAX) ? AREA_MAX : half[AREA_W-1:0];
    endfunction

    function automatic logic [PERIM_W-1:0] perim_add(input logic [PERIM_W-1:0] s,
                                                     input logic [PERIM_W-1:0] d);
        logic [PERIM_W:0] t;
        t = {1'b0, s} + d;
        return t[PERIM_W] ? PERIM_MAX : t[PERIM_W-1:0];
    endfunction

    function automatic logic [AREA_W-1:0] area_add(input logic [AREA_W-1:0] s,
                                                   input logic [AREA_W-1:0] d);
        logic [AREA_W:0] t;
        t = {1'b0, s} + d;
        return t[AREA_W] ? AREA_MAX : t[AREA_W-1:0];
    endfunction

    // Advance the predicted figure by one accepted vertex. The last vertex
    // closes the figure, queues its summary and clears the accumulators.
    task automatic predict_vertex(input logic [IN_COORD_W-1:0] xin,
                                  input logic [IN_COORD_W-1:0] yin, input bit last);
        longint         x, y;
        figure_result_t res;
        x = $signed(xin);
        y = $signed(yin);
        if (fig_count == 0) begin
            fig_first_x = x;
            fig_first_y = y;
        end else begin
            fig_perim = perim_add(fig_perim, edge_length(fig_prev_x, fig_prev_y, x, y));
            if (fig_count >= 2) begin
                fig_area = area_add(fig_area, fan_triangle(fig_prev_x, fig_prev_y, x, y));
            end
        end
        fig_prev_x = x;
        fig_prev_y = y;
        if (fig_count < FIG_VERTEX_CAP) begin
            fig_count++;
        end
        if (last) begin
            if (closed_mode_q == MODE_CLOSED) begin
                fig_perim = perim_add(fig_perim,
                                      edge_length(x, y, fig_first_x, fig_first_y));
            end
            res.perimeter    = fig_perim;
            res.area         = fig_area;
            res.vertex_total = (fig_count > TOTAL_MAX) ? TOTAL_MAX : 11'(fig_count);
            expected_figures.push_back(res);
            fig_first_x = 0;
            fig_first_y = 0;
            fig_prev_x  = 0;
            fig_prev_y  = 0;
            fig_count   = 0;
            fig_perim   = '0;
            fig_area    = '0;
        end
    endtask

    // Offer one vertex, after an optional gap, and hold it until the block
    // takes it. The valid stays high into the next call when no gap follows,
    // so back-to-back transfers never drop it.
    task automatic send_vertex(input logic [IN_COORD_W-1:0] x,
                               input logic [IN_COORD_W-1:0] y, input bit last);
        int gap;
        gap = tx_steady ? 0 : rand_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_vertex(x, y, last);
        vertices_sent++;
    endtask

    // Stop sending, wait for every expected figure, then let the back end
    // settle in case a vertex without tlast is still being worked on.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_figures.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_closed_mode(input bit mode);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        closed_mode_q = mode;
        if (mode == MODE_OPEN) begin
            saw_mode_open = 1'b1;
        end else begin
            saw_mode_closed = 1'b1;
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [IN_COORD_W-1:0] pick_coord(input coord_pick_t how,
                                                         input logic [IN_COORD_W-1:0] anchor);
        case (how)
            PICK_FULL: begin
                return IN_COORD_W'($urandom());
            end
            PICK_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return 24'd1;
                endcase
            end
            PICK_REPEAT: begin
                return anchor;
            end
            default: begin
                return anchor + IN_COORD_W'($urandom_range(0, 4000)) - 24'd2000;
            end
        endcase
    endfunction

    // One figure of the given length with random content: mostly nearby
    // vertices, with some full-range jumps, extremes and repeated vertices.
    task automatic send_random_figure(input int length);
        logic [IN_COORD_W-1:0] x, y;
        coord_pick_t           how;
        int                    roll;
        x = IN_COORD_W'($urandom());
        y = IN_COORD_W'($urandom());
        for (int i = 0; i < length; i++) begin
            roll = $urandom_range(0, 99);
            how  = (roll < 15) ? PICK_FULL : (roll < 25) ? PICK_EXTREME :
                   (roll < 35) ? PICK_REPEAT : PICK_NEAR;
            x = pick_coord(how, x);
            y = pick_coord(how, y);
            send_vertex(x, y, i == length - 1);
        end
    endtask

    function automatic int random_figure_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return $urandom_range(1, 3);
        end else if (roll < 75) begin
            return $urandom_range(1, 8);
        end else if (roll < 97) begin
            return $urandom_range(9, 30);
        end
        return $urandom_range(31, 80);
    endfunction

    // Shapes with known answers in both modes. The first block runs with the
    // register still at its reset value, which must be closed mode.
    task automatic test_directed_shapes();
        // Unit square: perimeter 4.0 closed, area 1.0.
        send_vertex(24'd0,   24'd0,   1'b0);
        send_vertex(24'd256, 24'd0,   1'b0);
        send_vertex(24'd256, 24'd256, 1'b0);
        send_vertex(24'd0,   24'd256, 1'b1);
        // A lone vertex: nothing to measure, the closing edge is zero.
        send_vertex(24'd1234, 24'hFFF000, 1'b1);
        // Two vertices closed: the one edge is counted twice.
        send_vertex(24'd0,    24'd0, 1'b0);
        send_vertex(24'd768,  24'd1024, 1'b1);
        // Coordinates at both ends of the range.
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        // Repeated vertex: zero-length edges and a flat triangle.
        send_vertex(24'd500, 24'd500, 1'b0);
        send_vertex(24'd500, 24'd500, 1'b0);
        send_vertex(24'd500, 24'd500, 1'b1);
        // Collinear points: edges count, the area stays zero.
        send_vertex(24'hFFFF00, 24'hFFFF00, 1'b0);
        send_vertex(24'd256,    24'd256,    1'b0);
        send_vertex(24'd1024,   24'd1024,   1'b1);

        write_closed_mode(MODE_OPEN);
        send_vertex(24'd77, 24'd99, 1'b1);
        send_vertex(24'd0,  24'd0,  1'b0);
        send_vertex(24'd768, 24'd1024, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        write_closed_mode(MODE_CLOSED);
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering short figures without gaps. The output register and the input
    // queue fill, so s_tready must drop and then recover. Afterwards the
    // sender pauses until every expected result has come.
    task automatic test_backpressure();
        drain_block();
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_random_figure($urandom_range(1, 2));
        end
        tx_steady = 1'b0;
        drain_block();
    endtask

    // Random figures in phases. The register is written between phases and
    // some phases run with no idling on one or both sides.
    task automatic test_random_figures();
        int start_count, phase;
        start_count = vertices_sent;
        phase = 0;
        while (vertices_sent - start_count < RANDOM_VERTICES) begin
            if (phase < 2) begin
                write_closed_mode(phase == 0 ? MODE_OPEN : MODE_CLOSED);
            end else begin
                write_closed_mode(1'($urandom_range(0, 1)));
            end
            tx_steady = (phase % 4 == 3);
            rx_steady = (phase % 3 == 2);
            for (int f = 0; f < 20; f++) begin
                send_random_figure(random_figure_length());
            end
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver side: random stalls, steady stretches and the long hold-off,
    // which is counted here in cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            rx_stall_left = rand_gap();
            m_tready <= (rx_stall_left == 0);
            if (rx_stall_left > 0) begin
                rx_stall_left--;
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] figure %0d %s: expected %0d, got %0d",
                     $realtime, figures_checked, what, want, got);
        end
    endtask

    // Result checker: every result transfer is matched against the oldest
    // expected figure, field by field.
    always @(posedge aclk) begin
        figure_result_t want;
        logic [PERIM_W-1:0] got_perim;
        logic [AREA_W-1:0]  got_area;
        logic [TOTAL_W-1:0] got_total;
        if (aresetn && m_tvalid && m_tready) begin
            got_perim = m_tdata[PERIM_W-1:0];
            got_area  = m_tdata[PERIM_W +: AREA_W];
            got_total = m_tdata[PERIM_W + AREA_W +: TOTAL_W];
            if (expected_figures.size() == 0) begin
                note_mismatch("unexpected result, perimeter", '0, 64'(got_perim));
            end else begin
                want = expected_figures.pop_front();
                if (got_perim !== want.perimeter) begin
                    note_mismatch("perimeter", 64'(want.perimeter), 64'(got_perim));
                end
                if (got_area !== want.area) begin
                    note_mismatch("area", 64'(want.area), 64'(got_area));
                end
                if (got_total !== want.vertex_total) begin
                    note_mismatch("vertex_total", 64'(want.vertex_total), 64'(got_total));
                end
            end
            figures_checked++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d figures still outstanding",
                     cycle_count, expected_figures.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_shapes();
        test_backpressure();
        test_random_figures();
        drain_block();

        $display("covered %0d vertices in %0d figures, open %0b and closed %0b contours,",
                 vertices_sent, figures_checked, saw_mode_open, saw_mode_closed);
        $display("range extremes and a %0d-cycle receiver hold-off; %0d mismatches",
                 RX_HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0 && expected_figures.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ppa_pkg.sv
sv/ppa_front.sv
sv/ppa_fifo.sv
sv/ppa_back.sv
sv/polygon_perimeter_area_top.sv
sim/polygon_perimeter_area_top_tb.sv
